/* sv/twmmh_pkg.sv */
// shared types, constants and helpers for the two-word multiply-mix hash unit
package twmmh_pkg;

    localparam logic [63:0] MIX_MUL_A = 64'h9de62bbc8cef3ce3;
    localparam logic [63:0] MIX_MUL_B = 64'h485cd6311b599e79;
    localparam logic [63:0] FIN_MUL_A = 64'hbac3bd562846de6b;
    localparam logic [63:0] FIN_MUL_B = 64'h995a187a14e7b445;
    localparam int unsigned SHIFT_A = 31;
    localparam int unsigned SHIFT_B = 32;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned LEN_W   = 32;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned CHUNK_BYTES_MAX = 8;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_SHIFT,
        ST_MA0,
        ST_MA1,
        ST_MA2,
        ST_MB0,
        ST_MB1,
        ST_MB2,
        ST_ADDX,
        ST_DIG,
        ST_MFA0,
        ST_MFA1,
        ST_MFA2,
        ST_FOLD,
        ST_MFB0,
        ST_MFB1,
        ST_MFB2,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_SHIFT,
        OP_MUL,
        OP_ADDX,
        OP_DIG,
        OP_FOLD,
        OP_EMIT
    } op_t;

    // which partial product of the 64x64 low-half multiply
    typedef enum logic [1:0] {
        MS_LL,
        MS_HL,
        MS_LH
    } mstep_t;

    typedef enum logic [1:0] {
        SRC_A,
        SRC_B,
        SRC_H
    } src_t;

    typedef enum logic [1:0] {
        CS_MIX_A,
        CS_MIX_B,
        CS_FIN_A,
        CS_FIN_B
    } csel_t;

    typedef struct packed {
        op_t    op;
        mstep_t step;
        src_t   src;
        csel_t  csel;
    } cmd_t;

    typedef struct packed {
        logic in_chunk_nz;
        logic in_end;
        logic end_pending;
    } status_t;

    function automatic logic [63:0] const_value(csel_t sel);
        logic [63:0] v;
        unique case (sel)
            CS_MIX_A: v = MIX_MUL_A;
            CS_MIX_B: v = MIX_MUL_B;
            CS_FIN_A: v = FIN_MUL_A;
            CS_FIN_B: v = FIN_MUL_B;
            default:  v = MIX_MUL_A;
        endcase
        return v;
    endfunction

endpackage

/* sv/twmmh_item_if.sv */
// input item channel of the hash unit
interface twmmh_item_if;
    logic        valid;
    logic        ready;
    logic        start_hash;
    logic        start_segment;
    logic [31:0] segment_length;
    logic [63:0] chunk_data;
    logic [3:0]  chunk_bytes;
    logic        end_hash;

    modport source (
        output valid, start_hash, start_segment, segment_length,
               chunk_data, chunk_bytes, end_hash,
        input  ready
    );
    modport sink (
        input  valid, start_hash, start_segment, segment_length,
               chunk_data, chunk_bytes, end_hash,
        output ready
    );
endinterface

/* sv/twmmh_digest_if.sv */
// digest result channel of the hash unit
interface twmmh_digest_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest;

    modport source (
        output valid, digest,
        input  ready
    );
    modport sink (
        input  valid, digest,
        output ready
    );
endinterface

/* sv/twmmh_dpath.sv */
// datapath: accumulators, shared 32x32 multiplier and digest register
module twmmh_dpath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  twmmh_pkg::cmd_t        cmd,
    input  logic                   start_hash,
    input  logic                   start_segment,
    input  logic [31:0]            segment_length,
    input  logic [63:0]            chunk_data,
    input  logic [3:0]             chunk_bytes,
    input  logic                   end_hash,
    output twmmh_pkg::status_t     status,
    output logic [63:0]            digest
);

    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] digest_reg, digest_next;
    logic        end_reg, end_next;

    logic [63:0] a_start;
    logic [63:0] b_start;
    logic [63:0] chunk_mask;
    logic [63:0] sum_ab;
    logic [63:0] fold_sum;
    logic [63:0] mul_opnd;
    logic [63:0] mul_const;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;
    logic [63:0] mul_result;

    // byte i survives when it lies below the count; counts above eight keep all
    always_comb
    begin
        for (int i = 0; i < twmmh_pkg::CHUNK_BYTES_MAX; i++)
        begin
            chunk_mask[8*i +: 8] = (chunk_bytes > twmmh_pkg::COUNT_W'(i)) ? 8'hff : 8'h00;
        end
    end

    always_comb
    begin
        a_start = start_hash ? 64'd1 : a_reg;
        b_start = start_hash ? 64'd1 : b_reg;
        if (start_segment)
        begin
            a_start = a_start ^ {32'd0, segment_length};
        end
    end

    assign sum_ab   = a_reg + b_reg;
    assign fold_sum = h_reg + b_reg;

    always_comb
    begin
        unique case (cmd.src)
            twmmh_pkg::SRC_A: mul_opnd = a_reg;
            twmmh_pkg::SRC_B: mul_opnd = b_reg;
            twmmh_pkg::SRC_H: mul_opnd = h_reg;
            default:          mul_opnd = h_reg;
        endcase
        mul_const = twmmh_pkg::const_value(cmd.csel);
        unique case (cmd.step)
            twmmh_pkg::MS_LL:
            begin
                mul_x = mul_opnd[31:0];
                mul_y = mul_const[31:0];
            end
            twmmh_pkg::MS_HL:
            begin
                mul_x = mul_opnd[63:32];
                mul_y = mul_const[31:0];
            end
            twmmh_pkg::MS_LH:
            begin
                mul_x = mul_opnd[31:0];
                mul_y = mul_const[63:32];
            end
            default:
            begin
                mul_x = mul_opnd[31:0];
                mul_y = mul_const[31:0];
            end
        endcase
    end

    assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};
    // cross products only reach the upper half of the low 64 bits
    assign mul_result = {acc_reg[63:32] + mul_p[31:0], acc_reg[31:0]};

    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        h_next      = h_reg;
        x_next      = x_reg;
        acc_next    = acc_reg;
        digest_next = digest_reg;
        end_next    = end_reg;
        unique case (cmd.op)
            twmmh_pkg::OP_NONE:
            begin
            end
            twmmh_pkg::OP_LOAD:
            begin
                a_next   = a_start;
                b_next   = b_start;
                x_next   = chunk_data & chunk_mask;
                end_next = end_hash;
            end
            twmmh_pkg::OP_PREP:
            begin
                a_next = sum_ab;
                b_next = b_reg ^ sum_ab;
            end
            twmmh_pkg::OP_SHIFT:
            begin
                a_next = a_reg ^ (a_reg >> twmmh_pkg::SHIFT_A);
                b_next = b_reg ^ (b_reg >> twmmh_pkg::SHIFT_B);
            end
            twmmh_pkg::OP_MUL:
            begin
                if (cmd.step == twmmh_pkg::MS_LL)
                begin
                    acc_next = mul_p;
                end
                else if (cmd.step == twmmh_pkg::MS_HL)
                begin
                    acc_next = mul_result;
                end
                else
                begin
                    unique case (cmd.src)
                        twmmh_pkg::SRC_A: a_next = mul_result;
                        twmmh_pkg::SRC_B: b_next = mul_result;
                        twmmh_pkg::SRC_H: h_next = mul_result;
                        default:          h_next = mul_result;
                    endcase
                end
            end
            twmmh_pkg::OP_ADDX:
            begin
                a_next = a_reg + x_reg;
            end
            twmmh_pkg::OP_DIG:
            begin
                h_next = a_reg ^ (a_reg >> twmmh_pkg::SHIFT_A);
            end
            twmmh_pkg::OP_FOLD:
            begin
                h_next = fold_sum ^ (fold_sum >> twmmh_pkg::SHIFT_B);
            end
            twmmh_pkg::OP_EMIT:
            begin
                digest_next = h_reg;
                end_next    = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg   <= 64'd1;
            b_reg   <= 64'd1;
            end_reg <= 1'b0;
        end
        else
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            end_reg <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg      <= h_next;
        x_reg      <= x_next;
        acc_reg    <= acc_next;
        digest_reg <= digest_next;
    end

    assign status.in_chunk_nz = (chunk_bytes != 4'd0);
    assign status.in_end      = end_hash;
    assign status.end_pending = end_reg;
    assign digest             = digest_reg;

endmodule

/* sv/twmmh_ctrl.sv */
// controller: sequences the mix, multiply and digest steps and owns the handshakes
module twmmh_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  twmmh_pkg::status_t     status,
    output twmmh_pkg::cmd_t        cmd
);

    twmmh_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic emit_ok;

    assign emit_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            twmmh_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (status.in_chunk_nz)
                        state_next = twmmh_pkg::ST_PREP;
                    else if (status.in_end)
                        state_next = twmmh_pkg::ST_DIG;
                    else
                        state_next = twmmh_pkg::ST_IDLE;
                end
            end
            twmmh_pkg::ST_PREP:  state_next = twmmh_pkg::ST_SHIFT;
            twmmh_pkg::ST_SHIFT: state_next = twmmh_pkg::ST_MA0;
            twmmh_pkg::ST_MA0:   state_next = twmmh_pkg::ST_MA1;
            twmmh_pkg::ST_MA1:   state_next = twmmh_pkg::ST_MA2;
            twmmh_pkg::ST_MA2:   state_next = twmmh_pkg::ST_MB0;
            twmmh_pkg::ST_MB0:   state_next = twmmh_pkg::ST_MB1;
            twmmh_pkg::ST_MB1:   state_next = twmmh_pkg::ST_MB2;
            twmmh_pkg::ST_MB2:   state_next = twmmh_pkg::ST_ADDX;
            twmmh_pkg::ST_ADDX:
                state_next = status.end_pending ? twmmh_pkg::ST_DIG : twmmh_pkg::ST_IDLE;
            twmmh_pkg::ST_DIG:   state_next = twmmh_pkg::ST_MFA0;
            twmmh_pkg::ST_MFA0:  state_next = twmmh_pkg::ST_MFA1;
            twmmh_pkg::ST_MFA1:  state_next = twmmh_pkg::ST_MFA2;
            twmmh_pkg::ST_MFA2:  state_next = twmmh_pkg::ST_FOLD;
            twmmh_pkg::ST_FOLD:  state_next = twmmh_pkg::ST_MFB0;
            twmmh_pkg::ST_MFB0:  state_next = twmmh_pkg::ST_MFB1;
            twmmh_pkg::ST_MFB1:  state_next = twmmh_pkg::ST_MFB2;
            twmmh_pkg::ST_MFB2:  state_next = twmmh_pkg::ST_EMIT;
            twmmh_pkg::ST_EMIT:
                state_next = emit_ok ? twmmh_pkg::ST_IDLE : twmmh_pkg::ST_EMIT;
            default:             state_next = twmmh_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = twmmh_pkg::OP_NONE;
        cmd.step = twmmh_pkg::MS_LL;
        cmd.src  = twmmh_pkg::SRC_A;
        cmd.csel = twmmh_pkg::CS_MIX_A;
        in_ready = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            twmmh_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = twmmh_pkg::OP_LOAD;
            end
            twmmh_pkg::ST_PREP:  cmd.op = twmmh_pkg::OP_PREP;
            twmmh_pkg::ST_SHIFT: cmd.op = twmmh_pkg::OP_SHIFT;
            twmmh_pkg::ST_MA0, twmmh_pkg::ST_MA1, twmmh_pkg::ST_MA2:
            begin
                cmd.op   = twmmh_pkg::OP_MUL;
                cmd.src  = twmmh_pkg::SRC_A;
                cmd.csel = twmmh_pkg::CS_MIX_A;
            end
            twmmh_pkg::ST_MB0, twmmh_pkg::ST_MB1, twmmh_pkg::ST_MB2:
            begin
                cmd.op   = twmmh_pkg::OP_MUL;
                cmd.src  = twmmh_pkg::SRC_B;
                cmd.csel = twmmh_pkg::CS_MIX_B;
            end
            twmmh_pkg::ST_ADDX: cmd.op = twmmh_pkg::OP_ADDX;
            twmmh_pkg::ST_DIG:  cmd.op = twmmh_pkg::OP_DIG;
            twmmh_pkg::ST_MFA0, twmmh_pkg::ST_MFA1, twmmh_pkg::ST_MFA2:
            begin
                cmd.op   = twmmh_pkg::OP_MUL;
                cmd.src  = twmmh_pkg::SRC_H;
                cmd.csel = twmmh_pkg::CS_FIN_A;
            end
            twmmh_pkg::ST_FOLD: cmd.op = twmmh_pkg::OP_FOLD;
            twmmh_pkg::ST_MFB0, twmmh_pkg::ST_MFB1, twmmh_pkg::ST_MFB2:
            begin
                cmd.op   = twmmh_pkg::OP_MUL;
                cmd.src  = twmmh_pkg::SRC_H;
                cmd.csel = twmmh_pkg::CS_FIN_B;
            end
            twmmh_pkg::ST_EMIT:
            begin
                if (emit_ok)
                begin
                    cmd.op         = twmmh_pkg::OP_EMIT;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // partial product order within each multiply
        unique case (state_reg)
            twmmh_pkg::ST_MA1, twmmh_pkg::ST_MB1, twmmh_pkg::ST_MFA1, twmmh_pkg::ST_MFB1:
                cmd.step = twmmh_pkg::MS_HL;
            twmmh_pkg::ST_MA2, twmmh_pkg::ST_MB2, twmmh_pkg::ST_MFA2, twmmh_pkg::ST_MFB2:
                cmd.step = twmmh_pkg::MS_LH;
            default:
                cmd.step = twmmh_pkg::MS_LL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= twmmh_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* sv/two_word_multiply_mix_hash_unit.sv */
// top level of the two-word multiply-mix hash unit
//
// item: valid/ready channel of message items. each transaction may restart the
//   hash, open a segment (xor of its length into the first word), absorb one
//   chunk of up to eight little-endian bytes and ask for the digest.
// result: valid/ready channel carrying one 64-bit digest per item with end_hash.
// sequencing: all work runs through one shared 32x32 multiplier, each 64-bit
//   product built from its low-low, high-low and low-high partial products in
//   turn. an item with no chunk and no end_hash is only accepted; a chunk runs
//   accept, mix prep, shift, two products and chunk add. a digest adds shift,
//   product, fold, product and output load, after the chunk steps or straight
//   after the accept. the next item is taken as soon as the previous one has
//   left the sequencer.
// stall: the digest sits in an output register; the block keeps taking items
//   while it waits and only holds in its output step if a new digest is ready
//   before the old one is taken.
// reset: both accumulators return to one and the output register empties.
module two_word_multiply_mix_hash_unit (
    input  logic            clk,
    input  logic            rst_n,
    twmmh_item_if.sink      item,
    twmmh_digest_if.source  result
);

    twmmh_pkg::cmd_t    cmd;
    twmmh_pkg::status_t status;
    logic               in_ready;
    logic               out_valid;
    logic [63:0]        digest;

    twmmh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    twmmh_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .start_hash     (item.start_hash),
        .start_segment  (item.start_segment),
        .segment_length (item.segment_length),
        .chunk_data     (item.chunk_data),
        .chunk_bytes    (item.chunk_bytes),
        .end_hash       (item.end_hash),
        .status         (status),
        .digest         (digest)
    );

    assign item.ready    = in_ready;
    assign result.valid  = out_valid;
    assign result.digest = digest;

    // an item with no work frees the sequencer at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && in_ready && item.chunk_bytes == 4'd0 && !item.end_hash)
        |=> in_ready)
    else $error("idle item did not free the sequencer");

    // an item with a chunk or a digest request keeps the input closed next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && in_ready && (item.chunk_bytes != 4'd0 || item.end_hash))
        |=> !in_ready)
    else $error("input reopened while an item is in progress");

    // a digest appears only after the output load step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.op == twmmh_pkg::OP_EMIT))
    else $error("digest valid without an output load");

endmodule

/* verif/tb_two_word_multiply_mix_hash_unit.sv */
// self-checking testbench for the two-word multiply-mix hash unit
module tb_two_word_multiply_mix_hash_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 1050;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam realtime     RUN_LIMIT    = 8_000_000ns;

    typedef struct packed {
        bit        start_hash;
        bit        start_segment;
        bit [31:0] segment_length;
        bit [63:0] chunk_data;
        bit [3:0]  chunk_bytes;
        bit        end_hash;
    } hash_item_t;

    // keeps its own copy of both accumulators and the digests still owed
    class hash_tracker;
        bit [63:0] acc_a;
        bit [63:0] acc_b;
        bit [63:0] digests_due[$];
        int        errors;

        function new();
            acc_a  = 64'd1;
            acc_b  = 64'd1;
            errors = 0;
        endfunction

        function void absorb_item(hash_item_t it);
            bit [63:0]   x;
            bit [63:0]   h;
            int unsigned n;
            if (it.start_hash)
            begin
                acc_a = 64'd1;
                acc_b = 64'd1;
            end
            if (it.start_segment)
                acc_a ^= {32'd0, it.segment_length};
            if (it.chunk_bytes != 4'd0)
            begin
                n = (it.chunk_bytes > twmmh_pkg::CHUNK_BYTES_MAX) ?
                    twmmh_pkg::CHUNK_BYTES_MAX : 32'(it.chunk_bytes);
                x = it.chunk_data;
                if (n < twmmh_pkg::CHUNK_BYTES_MAX)
                    x &= (64'd1 << (8 * n)) - 64'd1;
                acc_a = acc_a + acc_b;
                acc_b ^= acc_a;
                acc_a ^= acc_a >> twmmh_pkg::SHIFT_A;
                acc_a = acc_a * twmmh_pkg::MIX_MUL_A;
                acc_b ^= acc_b >> twmmh_pkg::SHIFT_B;
                acc_b = acc_b * twmmh_pkg::MIX_MUL_B;
                acc_a = acc_a + x;
            end
            if (it.end_hash)
            begin
                h = acc_a;
                h ^= h >> twmmh_pkg::SHIFT_A;
                h = h * twmmh_pkg::FIN_MUL_A;
                h = h + acc_b;
                h ^= h >> twmmh_pkg::SHIFT_B;
                h = h * twmmh_pkg::FIN_MUL_B;
                digests_due.push_back(h);
            end
        endfunction

        function void check_digest(bit [63:0] got);
            bit [63:0] want;
            if (digests_due.size() == 0)
            begin
                $display("%0t unexpected digest: expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = digests_due.pop_front();
            if (got !== want)
            begin
                $display("%0t digest mismatch: expected %h actual %h", $time, want, got);
                errors++;
            end
        endfunction

        function int outstanding();
            return digests_due.size();
        endfunction
    endclass

    bit   clk = 1'b0;
    logic rst_n;

    twmmh_item_if   item_ch ();
    twmmh_digest_if digest_ch ();

    two_word_multiply_mix_hash_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (digest_ch)
    );

    hash_tracker tracker = new();
    int unsigned items_sent = 0;

    always #6ns clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic hash_item_t random_item();
        hash_item_t it;
        it.start_hash     = 1'($urandom_range(0, 1));
        it.start_segment  = 1'($urandom_range(0, 1));
        it.segment_length = $urandom;
        it.chunk_data     = {$urandom, $urandom};
        it.chunk_bytes    = 4'($urandom_range(0, 15));
        it.end_hash       = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // offer one transaction, note it when taken, then possibly idle for a random gap
    task automatic feed_item(hash_item_t it);
        int unsigned gap;
        item_ch.valid          <= 1'b1;
        item_ch.start_hash     <= it.start_hash;
        item_ch.start_segment  <= it.start_segment;
        item_ch.segment_length <= it.segment_length;
        item_ch.chunk_data     <= it.chunk_data;
        item_ch.chunk_bytes    <= it.chunk_bytes;
        item_ch.end_hash       <= it.end_hash;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        tracker.absorb_item(it);
        items_sent++;
        // every fourth stretch of 150 items runs back to back
        gap = ((items_sent / 150) % 4 == 3) ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic push_item(bit sh, bit ss, bit [31:0] len, bit [63:0] data,
                             bit [3:0] nb, bit eh);
        hash_item_t it;
        it.start_hash     = sh;
        it.start_segment  = ss;
        it.segment_length = len;
        it.chunk_data     = data;
        it.chunk_bytes    = nb;
        it.end_hash       = eh;
        feed_item(it);
    endtask

    // a message built from segments whose chunk counts mostly match their lengths
    task automatic send_message();
        hash_item_t  it;
        int unsigned nseg;
        int unsigned nchunks;
        int unsigned remaining;
        int unsigned r;
        bit [31:0]   len;
        bit          fresh;
        bit          split_end;
        fresh     = ($urandom_range(0, 9) != 0);
        split_end = ($urandom_range(0, 4) == 0);
        nseg      = $urandom_range(1, 3);
        for (int s = 0; s < nseg; s++)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                len     = $urandom;
                nchunks = $urandom_range(0, 4);
            end
            else if (r == 1)
            begin
                len     = 32'd0;
                nchunks = 0;
            end
            else
            begin
                len     = $urandom_range(1, 40);
                nchunks = (len + 7) / 8;
                // length that disagrees with the delivered chunks
                if (r == 2)
                    nchunks = $urandom_range(0, 5);
            end
            remaining = len;
            for (int k = 0; k < ((nchunks == 0) ? 1 : nchunks); k++)
            begin
                it = random_item();
                it.start_hash    = fresh && (s == 0) && (k == 0);
                it.start_segment = (k == 0);
                if (nchunks == 0)
                    it.chunk_bytes = 4'd0;
                else if (remaining >= twmmh_pkg::CHUNK_BYTES_MAX)
                    it.chunk_bytes = 4'(twmmh_pkg::CHUNK_BYTES_MAX);
                else if (remaining > 0)
                    it.chunk_bytes = 4'(remaining);
                else
                    it.chunk_bytes = 4'($urandom_range(1, 8));
                remaining = (remaining > it.chunk_bytes) ? remaining - it.chunk_bytes : 0;
                if (it.chunk_bytes == twmmh_pkg::CHUNK_BYTES_MAX && $urandom_range(0, 9) == 0)
                    it.chunk_bytes = 4'($urandom_range(9, 15));
                it.segment_length = it.start_segment ? len : $urandom;
                it.end_hash = !split_end && (s == nseg - 1) &&
                              (k == ((nchunks == 0) ? 0 : nchunks - 1));
                feed_item(it);
            end
        end
        if (split_end)
        begin
            it = random_item();
            it.start_hash    = 1'b0;
            it.start_segment = 1'b0;
            it.chunk_bytes   = 4'd0;
            it.end_hash      = 1'b1;
            feed_item(it);
        end
    endtask

    // receiver: random backpressure, calm stretches and one long hold
    initial
    begin
        int unsigned stall_left;
        int unsigned cycles;
        int unsigned seen;
        bit          held;
        stall_left = 0;
        cycles     = 0;
        seen       = 0;
        held       = 1'b0;
        digest_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cycles++;
            if (digest_ch.valid === 1'b1 && digest_ch.ready === 1'b1)
            begin
                tracker.check_digest(digest_ch.digest);
                seen++;
            end
            if (!held && seen >= 25)
            begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                digest_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                digest_ch.ready <= 1'b1;
                if ((cycles / 300) % 4 != 1)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        item_ch.valid          <= 1'b0;
        item_ch.start_hash     <= 1'b0;
        item_ch.start_segment  <= 1'b0;
        item_ch.segment_length <= '0;
        item_ch.chunk_data     <= '0;
        item_ch.chunk_bytes    <= '0;
        item_ch.end_hash       <= 1'b0;
        rst_n                  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // digest straight after reset, no data
        push_item(1'b0, 1'b0, 32'd0, 64'd0, 4'd0, 1'b1);
        push_item(1'b1, 1'b1, 32'd8, '1, 4'd8, 1'b1);
        push_item(1'b1, 1'b1, 32'hffff_ffff, '1, 4'd0, 1'b1);
        push_item(1'b1, 1'b1, 32'd0, 64'd0, 4'd8, 1'b1);
        // unused bytes above the count are masked
        for (int n = 1; n < 8; n++)
            push_item(1'b1, 1'b1, 32'(n), '1, 4'(n), 1'b1);
        // oversized counts behave as eight
        push_item(1'b1, 1'b1, 32'd8, '1, 4'd9, 1'b1);
        push_item(1'b1, 1'b1, 32'd8, 64'h0123_4567_89ab_cdef, 4'd15, 1'b1);
        // segment length that does not match the chunks
        push_item(1'b1, 1'b1, 32'd3, 64'hfedc_ba98_7654_3210, 4'd8, 1'b0);
        push_item(1'b0, 1'b0, 32'hffff_ffff, '1, 4'd8, 1'b1);
        // accumulators kept after a digest
        push_item(1'b0, 1'b0, 32'd0, 64'h5555_5555_5555_5555, 4'd4, 1'b1);
        push_item(1'b0, 1'b1, 32'h8000_0000, 64'haaaa_aaaa_aaaa_aaaa, 4'd8, 1'b0);
        push_item(1'b0, 1'b1, 32'd12, 64'h8000_0000_0000_0001, 4'd8, 1'b0);
        push_item(1'b0, 1'b0, 32'd0, 64'hffff_ffff_0000_0000, 4'd4, 1'b0);
        push_item(1'b0, 1'b0, 32'd0, 64'd0, 4'd0, 1'b1);

        while (items_sent < RANDOM_ITEMS + 20)
        begin
            if ($urandom_range(0, 7) == 0)
                feed_item(random_item());
            else
                send_message();
        end
        item_ch.valid <= 1'b0;

        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.outstanding() != 0)
        begin
            $display("%0t digests never delivered: expected %0d actual 0",
                     $time, tracker.outstanding());
            tracker.errors++;
        end

        if (tracker.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* two_word_multiply_mix_hash_unit.f */
sv/twmmh_pkg.sv
sv/twmmh_item_if.sv
sv/twmmh_digest_if.sv
sv/twmmh_dpath.sv
sv/twmmh_ctrl.sv
sv/two_word_multiply_mix_hash_unit.sv
verif/tb_two_word_multiply_mix_hash_unit.sv
